>>> hdl/mbq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_pkg: shared types and constants of the CAN mailbox receive queues
// Field widths, command codes, the classified queue entry and the frame
// record that the ring storage holds.
// ---------------------------------------------------------------------------
package mbq_pkg;

  // Default sizes of the queue set.
  localparam int QUEUE_SLOTS_DEF   = 16;
  localparam int MAILBOX_COUNT_DEF = 7;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int MB_W      = 3;
  localparam int IDENT_W   = 29;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 64;
  localparam int ENABLE_W  = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Depth of the queue between the front and the back part.
  localparam int FIFO_DEPTH = 2;

  // Mailbox number that is never valid.
  localparam logic [MB_W-1:0] INVALID_MAILBOX = 3'd7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Register index of the mailbox enable register.
  localparam logic REG_MAILBOX_ENABLE = 1'b0;

  // One received CAN frame as stored in a ring slot.
  typedef struct packed {
    logic [IDENT_W-1:0]   ident;
    logic                 extended;
    logic                 remote;
    logic [LEN_W-1:0]     length;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  // A classified command on its way from the front to the back part.
  typedef struct packed {
    logic            is_push;
    logic            is_pop;
    logic            is_clear;
    logic            mb_ok;
    logic            en_ok;
    logic [MB_W-1:0] mb;
    frame_t          frame;
  } item_t;

  // Enable register write event: which mailboxes changed their enable bit.
  typedef struct packed {
    logic                wr;
    logic [ENABLE_W-1:0] changed;
  } cfg_evt_t;

  // One result item.
  typedef struct packed {
    logic   ok;
    logic   dropped;
    frame_t frame;
  } result_t;

endpackage

>>> hdl/can_mailbox_rx_queues_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// can_mailbox_rx_queues_unit: CAN receive mailbox ring queues
// Per-mailbox ring buffers of received frames with push, pop and clear
// commands and an APB-style enable register.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  --------------------------------------
//   config   psel/penable/pwrite       paddr, pwdata, prdata (enable at 0x0)
//   input    in_valid / in_ready       cmd, mailbox_num, frame_*
//   output   out_valid / out_ready     ok, dropped, out_*
//
// One item per cycle sustained while the output is not stalled; each item
// takes at most one storage access and one pointer update. An accepted item
// is written into the item queue, then issued from it together with the
// registered storage read into the pending stage, and then loaded into the
// result register. Reset is synchronous and clears pointers and control only;
// the frame storage needs no clearing pass. A stalled output backs up into
// the two-entry item queue, and in_ready drops once that queue is full.
//
module can_mailbox_rx_queues_unit
  import mbq_pkg::*;
#(
  parameter int QUEUE_SLOTS   = QUEUE_SLOTS_DEF,
  parameter int MAILBOX_COUNT = MAILBOX_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [MB_W-1:0]      mailbox_num,
  input  logic [IDENT_W-1:0]   frame_ident,
  input  logic                 frame_extended,
  input  logic                 frame_remote,
  input  logic [LEN_W-1:0]     frame_length,
  input  logic [PAYLOAD_W-1:0] frame_payload,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 ok,
  output logic                 dropped,
  output logic [IDENT_W-1:0]   out_ident,
  output logic                 out_extended,
  output logic                 out_remote,
  output logic [LEN_W-1:0]     out_length,
  output logic [PAYLOAD_W-1:0] out_payload
);

  logic [ENABLE_W-1:0] mailbox_enable;
  logic [ENABLE_W-1:0] mailbox_enable_next;
  logic                en_sel;
  logic                en_wr;
  cfg_evt_t            cfg_evt;
  item_t               front_item;
  item_t               q_item;
  logic                q_valid;
  logic                q_ready;
  result_t             result;

  // Register port: one enable register, written in the access phase.
  assign pready              = 1'b1;
  assign en_sel              = (paddr[2] == REG_MAILBOX_ENABLE);
  assign en_wr               = psel && penable && pwrite && pready && en_sel;
  assign mailbox_enable_next = pwdata[ENABLE_W-1:0];
  assign prdata              = en_sel ? PDATA_W'(mailbox_enable) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mailbox_enable <= '0;
    end else if (en_wr) begin
      mailbox_enable <= mailbox_enable_next;
    end
  end

  // Mailboxes whose enable bit flips get their ring cleared.
  assign cfg_evt.wr      = en_wr;
  assign cfg_evt.changed = mailbox_enable_next ^ mailbox_enable;

  // Front part: classify the incoming item.
  mbq_front #(
    .MAILBOX_COUNT (MAILBOX_COUNT)
  ) u_front (
    .cmd            (cmd),
    .mailbox_num    (mailbox_num),
    .frame_ident    (frame_ident),
    .frame_extended (frame_extended),
    .frame_remote   (frame_remote),
    .frame_length   (frame_length),
    .frame_payload  (frame_payload),
    .mailbox_enable (mailbox_enable),
    .item           (front_item)
  );

  // Item queue between the two parts.
  mbq_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // Back part: ring pointers, frame storage and result register.
  mbq_back #(
    .QUEUE_SLOTS   (QUEUE_SLOTS),
    .MAILBOX_COUNT (MAILBOX_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_evt   (cfg_evt),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // Result fields onto the ports.
  assign ok           = result.ok;
  assign dropped      = result.dropped;
  assign out_ident    = result.frame.ident;
  assign out_extended = result.frame.extended;
  assign out_remote   = result.frame.remote;
  assign out_length   = result.frame.length;
  assign out_payload  = result.frame.payload;

  // A result is never both stored and dropped.
  a_ok_dropped_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ok && dropped))
    else $error("result both ok and dropped");

  // Any result that is not ok carries an all-zero frame.
  a_zero_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (out_ident == '0 && out_length == '0 &&
                            out_payload == '0 && !out_extended && !out_remote))
    else $error("failed command returned frame data");

  // A dropped result can only come from a push.
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped) |-> (out_payload == '0 && out_ident == '0))
    else $error("dropped result returned frame data");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

>>> hdl/mbq_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_front: command classifier
// Decodes the command, checks the mailbox number and its enable bit, and
// packs the frame into one queue entry.
// ---------------------------------------------------------------------------
module mbq_front
  import mbq_pkg::*;
#(
  parameter int MAILBOX_COUNT = MAILBOX_COUNT_DEF
) (
  input  logic [CMD_W-1:0]     cmd,
  input  logic [MB_W-1:0]      mailbox_num,
  input  logic [IDENT_W-1:0]   frame_ident,
  input  logic                 frame_extended,
  input  logic                 frame_remote,
  input  logic [LEN_W-1:0]     frame_length,
  input  logic [PAYLOAD_W-1:0] frame_payload,
  input  logic [ENABLE_W-1:0]  mailbox_enable,
  output item_t                item
);

  logic [ENABLE_W:0] enable_ext;
  logic              mb_ok;

  // The mailbox must be in range and not the reserved number.
  assign mb_ok      = (mailbox_num != INVALID_MAILBOX) &&
                      (int'(mailbox_num) < MAILBOX_COUNT);
  assign enable_ext = {1'b0, mailbox_enable};

  // Classification of the item.
  always_comb begin
    item.is_push        = (cmd == CMD_PUSH);
    item.is_pop         = (cmd == CMD_POP);
    item.is_clear       = (cmd == CMD_CLEAR);
    item.mb_ok          = mb_ok;
    item.en_ok          = mb_ok && enable_ext[mailbox_num];
    item.mb             = mailbox_num;
    item.frame.ident    = frame_ident;
    item.frame.extended = frame_extended;
    item.frame.remote   = frame_remote;
    item.frame.length   = frame_length;
    item.frame.payload  = frame_payload;
  end

endmodule

>>> hdl/mbq_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_fifo: short item queue
// Decouples the classifier from the queue engine so that each side can
// stall on its own.
// ---------------------------------------------------------------------------
module mbq_fifo
  import mbq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CNT_W'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/mbq_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_back: ring queue engine
// Holds the head and tail pointer of every mailbox ring and the frame
// storage, carries out push, pop and clear, and drives the result register.
// ---------------------------------------------------------------------------
module mbq_back
  import mbq_pkg::*;
#(
  parameter int QUEUE_SLOTS   = QUEUE_SLOTS_DEF,
  parameter int MAILBOX_COUNT = MAILBOX_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_evt_t cfg_evt,
  input  logic     q_valid,
  output logic     q_ready,
  input  item_t    q_item,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  result
);

  // Only mailboxes below the reserved number can ever be addressed.
  localparam int MB_USED   = (MAILBOX_COUNT < int'(INVALID_MAILBOX)) ?
                             MAILBOX_COUNT : int'(INVALID_MAILBOX);
  localparam int MBI_W     = (MB_USED > 1) ? $clog2(MB_USED) : 1;
  localparam int PW        = $clog2(QUEUE_SLOTS);
  localparam int MEM_DEPTH = MB_USED * QUEUE_SLOTS;
  localparam int AW        = $clog2(MEM_DEPTH);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [PW-1:0]    head [MB_USED];
  logic [PW-1:0]    tail [MB_USED];
  frame_t           mem  [MEM_DEPTH];
  frame_t           rdata;

  logic [MBI_W-1:0] mbi;
  logic [PW-1:0]    cur_head;
  logic [PW-1:0]    cur_tail;
  logic [PW-1:0]    head_nxt;
  logic [AW-1:0]    addr;
  logic             push_good;
  logic             pop_good;
  logic             clr_good;
  logic             issue;
  logic             pend_adv;

  logic             pend_valid;
  logic             pend_ok;
  logic             pend_dropped;
  logic             pend_pop;

  // Pointer lookup for the mailbox at the head of the queue.
  assign mbi      = q_item.mb[MBI_W-1:0];
  assign cur_head = head[mbi];
  assign cur_tail = tail[mbi];
  assign head_nxt = ring_next(cur_head);

  // Outcome of the command, before it is issued.
  always_comb begin
    push_good = q_item.is_push && q_item.en_ok && (head_nxt != cur_tail);
    pop_good  = q_item.is_pop && q_item.mb_ok && (cur_tail != cur_head);
    clr_good  = q_item.is_clear && q_item.mb_ok;
    addr      = AW'(int'(mbi) * QUEUE_SLOTS +
                    int'(q_item.is_push ? cur_head : cur_tail));
  end

  // Two-stage flow: issue into the pending stage, then into the result register.
  assign pend_adv = pend_valid && (!out_valid || out_ready);
  assign q_ready  = !pend_valid || pend_adv;
  assign issue    = q_valid && q_ready;

  // Frame storage: at most one write or one registered read per issued item.
  always_ff @(posedge clk) begin
    if (issue && push_good) begin
      mem[addr] <= q_item.frame;
    end
    if (issue && pop_good) begin
      rdata <= mem[addr];
    end
  end

  // Ring pointers; an enable change clears the affected rings.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MB_USED; m++) begin
        head[m] <= '0;
        tail[m] <= '0;
      end
    end else begin
      for (int m = 0; m < MB_USED; m++) begin
        if (cfg_evt.wr && cfg_evt.changed[m]) begin
          head[m] <= '0;
          tail[m] <= '0;
        end else if (issue && q_item.mb_ok && (mbi == MBI_W'(m))) begin
          if (clr_good) begin
            head[m] <= '0;
            tail[m] <= '0;
          end else if (push_good) begin
            head[m] <= head_nxt;
          end else if (pop_good) begin
            tail[m] <= ring_next(cur_tail);
          end
        end
      end
    end
  end

  // Pending stage: result flags while the read data settles.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (issue) begin
      pend_valid <= 1'b1;
    end else if (pend_adv) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_ok      <= push_good || pop_good || clr_good;
      pend_dropped <= q_item.is_push && !push_good;
      pend_pop     <= pop_good;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv) begin
      result.ok      <= pend_ok;
      result.dropped <= pend_dropped;
      result.frame   <= pend_pop ? rdata : '0;
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench of the CAN mailbox receive queues
// Drives push, pop, clear and unused commands with random idling on both channels,
// predicts every result from a local copy of the ring pointers, the frame
// storage and the enable register, and compares each result field by field.
// ---------------------------------------------------------------------------
module tb;
  import mbq_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_SLOTS_DEF);

  // Codes that the package does not name.
  localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_ENABLE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SPARE  = 3'd4;

  // One command item as the driver presents it.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [MB_W-1:0]  mb;
    frame_t           frame;
  } cmd_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = '0;
  logic [MB_W-1:0]      mailbox_num = '0;
  logic [IDENT_W-1:0]   frame_ident = '0;
  logic                 frame_extended = 1'b0;
  logic                 frame_remote = 1'b0;
  logic [LEN_W-1:0]     frame_length = '0;
  logic [PAYLOAD_W-1:0] frame_payload = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 ok;
  logic                 dropped;
  logic [IDENT_W-1:0]   out_ident;
  logic                 out_extended;
  logic                 out_remote;
  logic [LEN_W-1:0]     out_length;
  logic [PAYLOAD_W-1:0] out_payload;

  // Predictor state: enable register, ring pointers and frame storage.
  logic [ENABLE_W-1:0] rx_enable = '0;
  logic [SLOT_W-1:0]   head_ptr [MAILBOX_COUNT_DEF];
  logic [SLOT_W-1:0]   tail_ptr [MAILBOX_COUNT_DEF];
  frame_t              ring_store [MAILBOX_COUNT_DEF][QUEUE_SLOTS_DEF];

  cmd_item_t pending_cmds[$];
  result_t   expected_results[$];
  cmd_item_t cur_cmd;
  int        send_idle_pct = 21;
  int        recv_idle_pct = 62;
  int        err_count = 0;

  can_mailbox_rx_queues_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .mailbox_num    (mailbox_num),
    .frame_ident    (frame_ident),
    .frame_extended (frame_extended),
    .frame_remote   (frame_remote),
    .frame_length   (frame_length),
    .frame_payload  (frame_payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .dropped        (dropped),
    .out_ident      (out_ident),
    .out_extended   (out_extended),
    .out_remote     (out_remote),
    .out_length     (out_length),
    .out_payload    (out_payload)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit mailbox_ok(input logic [MB_W-1:0] mb);
    return (mb != INVALID_MAILBOX) && (int'(mb) < MAILBOX_COUNT_DEF);
  endfunction

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
    return SLOT_W'((int'(p) + 1) % QUEUE_SLOTS_DEF);
  endfunction

  // Applies one command to the predicted queues and returns its result.
  function automatic result_t mailbox_queue_step(input cmd_item_t it);
    result_t             res;
    logic [SLOT_W-1:0]   nxt;
    res = '0;
    case (it.cmd)
      CMD_PUSH: begin
        if (!mailbox_ok(it.mb)) begin
          res.dropped = 1'b1;
        end else if (!rx_enable[it.mb]) begin
          res.dropped = 1'b1;
        end else begin
          nxt = ring_next(head_ptr[it.mb]);
          if (nxt == tail_ptr[it.mb]) begin
            res.dropped = 1'b1;
          end else begin
            ring_store[it.mb][head_ptr[it.mb]] = it.frame;
            head_ptr[it.mb] = nxt;
            res.ok = 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (mailbox_ok(it.mb) && tail_ptr[it.mb] != head_ptr[it.mb]) begin
          res.ok = 1'b1;
          res.frame = ring_store[it.mb][tail_ptr[it.mb]];
          tail_ptr[it.mb] = ring_next(tail_ptr[it.mb]);
        end
      end
      CMD_CLEAR: begin
        if (mailbox_ok(it.mb)) begin
          head_ptr[it.mb] = '0;
          tail_ptr[it.mb] = '0;
          res.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic cmd_item_t make_cmd(input logic [CMD_W-1:0] c, input logic [MB_W-1:0] mb,
                                         input logic [IDENT_W-1:0] ident, input logic ext,
                                         input logic rem, input logic [LEN_W-1:0] len,
                                         input logic [PAYLOAD_W-1:0] payload);
    cmd_item_t it;
    it.cmd = c;
    it.mb = mb;
    it.frame.ident = ident;
    it.frame.extended = ext;
    it.frame.remote = rem;
    it.frame.length = len;
    it.frame.payload = payload;
    return it;
  endfunction

  // Random command: the mix of commands and the favored mailboxes shape the fill level.
  function automatic cmd_item_t random_cmd(input int push_pct, input int pop_pct,
                                           input int hot_a, input int hot_b);
    cmd_item_t it;
    int        r;
    r = $urandom_range(0, 99);
    if (r < push_pct) it.cmd = CMD_PUSH;
    else if (r < push_pct + pop_pct) it.cmd = CMD_POP;
    else if (r < 97) it.cmd = CMD_CLEAR;
    else it.cmd = CMD_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 35) it.mb = MB_W'(hot_a);
    else if (r < 70) it.mb = MB_W'(hot_b);
    else it.mb = MB_W'($urandom_range(0, 7));
    it.frame.extended = 1'($urandom_range(0, 1));
    it.frame.remote = 1'($urandom_range(0, 1));
    it.frame.ident = IDENT_W'($urandom);
    if (!it.frame.extended) it.frame.ident[IDENT_W-1:11] = '0;
    if ($urandom_range(0, 99) < 85) it.frame.length = LEN_W'($urandom_range(0, 8));
    else it.frame.length = LEN_W'($urandom_range(9, 15));
    it.frame.payload = {$urandom, $urandom};
    return it;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      err_count++;
    end
  endtask

  // Waits until every item has been sent and every result has arrived.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase until pready.
  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [ENABLE_W-1:0] value);
    logic [PDATA_W-1:0]  data;
    logic [ENABLE_W-1:0] changed;
    data = $urandom;
    data[ENABLE_W-1:0] = value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // A changed enable bit empties that mailbox's queue.
    if (addr == ADDR_ENABLE) begin
      changed = value ^ rx_enable;
      for (int m = 0; m < MAILBOX_COUNT_DEF; m++) begin
        if (changed[m]) begin
          head_ptr[m] = '0;
          tail_ptr[m] = '0;
        end
      end
      rx_enable = value;
    end
  endtask

  // Driver: presents pending items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(mailbox_queue_step(cur_cmd));
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          cmd <= cur_cmd.cmd;
          mailbox_num <= cur_cmd.mb;
          frame_ident <= cur_cmd.frame.ident;
          frame_extended <= cur_cmd.frame.extended;
          frame_remote <= cur_cmd.frame.remote;
          frame_length <= cur_cmd.frame.length;
          frame_payload <= cur_cmd.frame.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no expectation, actual ok %0b dropped %0b",
                   $time, ok, dropped);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", 64'(want.ok), 64'(ok));
          check_field("dropped", 64'(want.dropped), 64'(dropped));
          check_field("out_ident", 64'(want.frame.ident), 64'(out_ident));
          check_field("out_extended", 64'(want.frame.extended), 64'(out_extended));
          check_field("out_remote", 64'(want.frame.remote), 64'(out_remote));
          check_field("out_length", 64'(want.frame.length), 64'(out_length));
          check_field("out_payload", want.frame.payload, out_payload);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    logic [ENABLE_W-1:0] enable_plan [8];
    int                  batch_len;
    int                  push_pct;
    int                  pop_pct;
    int                  hot_a;
    int                  hot_b;
    for (int m = 0; m < MAILBOX_COUNT_DEF; m++) begin
      head_ptr[m] = '0;
      tail_ptr[m] = '0;
    end
    enable_plan = '{7'h7f, 7'h55, 7'h7f, 7'h00, 7'(ENABLE_W'($urandom_range(1, 126))),
                    7'h7f, 7'h01, 7'h2a};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // With every mailbox disabled: drops, empty pops, clears and invalid numbers.
    reg_write(ADDR_ENABLE, 7'h00);
    reg_write(ADDR_SPARE, 7'h7f);
    @(negedge clk);
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd0, 29'h1234567, 1'b1, 1'b0, 4'd8, 64'hfeed));
    pending_cmds.push_back(make_cmd(CMD_POP, 3'd0, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 3'd3, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_UNUSED, 3'd2, '1, 1'b1, 1'b1, '1, '1));
    pending_cmds.push_back(make_cmd(CMD_PUSH, INVALID_MAILBOX, '1, 1'b1, 1'b1, 4'd8, '1));
    pending_cmds.push_back(make_cmd(CMD_POP, INVALID_MAILBOX, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, INVALID_MAILBOX, '0, 1'b0, 1'b0, 4'd0, '0));
    wait_idle();

    // All enabled: extreme field values, ordering, clear and an invalid push.
    reg_write(ADDR_ENABLE, 7'h7f);
    @(negedge clk);
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd0, '1, 1'b1, 1'b1, '1, '1));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd0, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd6, 29'h7ff, 1'b0, 1'b0, 4'd8,
                                    64'h0123456789abcdef));
    pending_cmds.push_back(make_cmd(CMD_PUSH, INVALID_MAILBOX, '1, 1'b1, 1'b0, 4'd3, '1));
    pending_cmds.push_back(make_cmd(CMD_POP, 3'd0, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_POP, 3'd0, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_POP, 3'd0, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_POP, 3'd6, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd2, 29'h15555555, 1'b1, 1'b0, 4'd1, 64'h5a));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd2, 29'h0aaaaaaa, 1'b1, 1'b1, 4'd2, 64'ha5));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 3'd2, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_POP, 3'd2, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd5, 29'h3c3, 1'b0, 1'b1, 4'd0, 64'h77));
    wait_idle();

    // Disabling a mailbox empties it; pushes drop but a clear still succeeds.
    reg_write(ADDR_ENABLE, 7'h5f);
    @(negedge clk);
    pending_cmds.push_back(make_cmd(CMD_POP, 3'd5, '0, 1'b0, 1'b0, 4'd0, '0));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 3'd5, 29'h1, 1'b0, 1'b0, 4'd4, 64'h1));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 3'd5, '0, 1'b0, 1'b0, 4'd0, '0));

    // Random batches: each under its own enable setting and command mix.
    for (int b = 0; b < 8; b++) begin
      wait_idle();
      if (b < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 62;
      end else if (b < 6) begin
        send_idle_pct = 62;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      reg_write(ADDR_ENABLE, enable_plan[b]);
      case (b % 3)
        0: begin
          push_pct = 80;
          pop_pct = 12;
        end
        1: begin
          push_pct = 50;
          pop_pct = 42;
        end
        default: begin
          push_pct = 15;
          pop_pct = 78;
        end
      endcase
      batch_len = (enable_plan[b] == 7'h00) ? 30 : 84;
      hot_a = $urandom_range(0, 7);
      hot_b = $urandom_range(0, 7);
      @(negedge clk);
      for (int n = 0; n < batch_len; n++) begin
        pending_cmds.push_back(random_cmd(push_pct, pop_pct, hot_a, hot_b));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
